// ===== src/hrms_pkg.sv =====
`default_nettype none
package hrms_pkg;

  localparam int BIN_W = 24;
  localparam int CNT_W = 11;
  localparam int SUM_W = 34;
  localparam int SQ_W = 58;
  localparam int ROW_W = 10;
  localparam int MEAN_W = 40;
  localparam int MSC_W = 43;
  localparam int STD_W = 40;
  localparam int STATUS_W = 2;
  localparam int TDATA_W = 152;

  // products and iterative units
  localparam int PROD_W = 69;
  localparam int DVS_W = 20;
  localparam int QUO_W = 101;
  localparam int RAD_W = 102;
  localparam int ROOT_W = 51;
  localparam int SREM_W = 53;

  localparam logic [CNT_W-1:0] MAX_BINS = 11'd1024;
  localparam logic [CNT_W-1:0] ROW_LIMIT = 11'd1024;

  localparam int CTR_W = 7;
  localparam logic [CTR_W-1:0] DIVM_STEPS = 7'd53;
  localparam logic [CTR_W-1:0] MUL_STEPS = 7'd34;
  localparam logic [CTR_W-1:0] DIVV_STEPS = 7'd101;
  localparam logic [CTR_W-1:0] SQRT_STEPS = 7'd51;

  localparam logic [STATUS_W-1:0] ST_VALID = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SINGLE = 2'd2;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DIVM_INIT,
    OP_DIV_STEP,
    OP_SAVE_MEAN,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_DIVV_INIT,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_FINISH
  } op_t;

  typedef struct packed {
    logic accept;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic slot_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/hrms_ctrl.sv =====
`default_nettype none
module hrms_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  input  wire                 s_tlast,
  input  wire                 s_tuser,
  output logic                s_tready,
  input  hrms_pkg::stat_t     stat,
  output hrms_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_ACC, S_DRAIN, S_START, S_DIVM, S_SAVEM, S_MULI, S_MUL,
    S_DIVVI, S_DIVV, S_SQRTI, S_SQRT, S_DONE
  } state_t;

  state_t state;
  logic [hrms_pkg::CTR_W-1:0] ctr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      ctr   <= '0;
    end else begin
      unique case (state)
        S_ACC: begin
          if (s_tvalid && (s_tlast || s_tuser)) state <= S_DRAIN;
        end
        S_DRAIN: state <= S_START;
        S_START: begin
          if (stat.n_zero) begin
            state <= S_DONE;
          end else begin
            ctr   <= hrms_pkg::DIVM_STEPS - 7'd1;
            state <= S_DIVM;
          end
        end
        S_DIVM: begin
          if (ctr == '0) state <= S_SAVEM;
          else ctr <= ctr - 7'd1;
        end
        S_SAVEM: state <= stat.n_one ? S_DONE : S_MULI;
        S_MULI: begin
          ctr   <= hrms_pkg::MUL_STEPS - 7'd1;
          state <= S_MUL;
        end
        S_MUL: begin
          if (ctr == '0) state <= S_DIVVI;
          else ctr <= ctr - 7'd1;
        end
        S_DIVVI: begin
          ctr   <= hrms_pkg::DIVV_STEPS - 7'd1;
          state <= S_DIVV;
        end
        S_DIVV: begin
          if (ctr == '0) state <= S_SQRTI;
          else ctr <= ctr - 7'd1;
        end
        S_SQRTI: begin
          ctr   <= hrms_pkg::SQRT_STEPS - 7'd1;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (ctr == '0) state <= S_DONE;
          else ctr <= ctr - 7'd1;
        end
        S_DONE: begin
          if (stat.slot_free) state <= S_ACC;
        end
        default: state <= S_ACC;
      endcase
    end
  end

  always_comb begin
    s_tready   = (state == S_ACC);
    cmd.accept = s_tready && s_tvalid;
    unique case (state)
      S_START: cmd.op = stat.n_zero ? hrms_pkg::OP_IDLE : hrms_pkg::OP_DIVM_INIT;
      S_DIVM:  cmd.op = hrms_pkg::OP_DIV_STEP;
      S_SAVEM: cmd.op = hrms_pkg::OP_SAVE_MEAN;
      S_MULI:  cmd.op = hrms_pkg::OP_MUL_INIT;
      S_MUL:   cmd.op = hrms_pkg::OP_MUL_STEP;
      S_DIVVI: cmd.op = hrms_pkg::OP_DIVV_INIT;
      S_DIVV:  cmd.op = hrms_pkg::OP_DIV_STEP;
      S_SQRTI: cmd.op = hrms_pkg::OP_SQRT_INIT;
      S_SQRT:  cmd.op = hrms_pkg::OP_SQRT_STEP;
      S_DONE:  cmd.op = stat.slot_free ? hrms_pkg::OP_FINISH : hrms_pkg::OP_IDLE;
      default: cmd.op = hrms_pkg::OP_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/hrms_datapath.sv =====
`default_nettype none
module hrms_datapath (
  input  wire                                 clk,
  input  wire                                 rst,
  input  hrms_pkg::cmd_t                      cmd,
  output hrms_pkg::stat_t                     stat,
  input  wire  [hrms_pkg::BIN_W-1:0]          bin_value,
  input  wire                                 row_end,
  input  wire                                 histogram_end,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [hrms_pkg::ROW_W-1:0]          row_index,
  output logic [hrms_pkg::CNT_W-1:0]          positive_bins,
  output logic [hrms_pkg::MEAN_W-1:0]         mean,
  output logic [hrms_pkg::MSC_W-1:0]          mean_fine,
  output logic [hrms_pkg::STD_W-1:0]          std_dev,
  output logic [hrms_pkg::STATUS_W-1:0]       status,
  output logic                                last_row
);

  // input stage
  logic                          pend;
  logic                          inc;
  logic [hrms_pkg::BIN_W-1:0]    bin_q;
  logic [2*hrms_pkg::BIN_W-1:0]  sq_q;
  logic                          hist_q;

  // row accumulators
  logic [hrms_pkg::CNT_W-1:0]    cnt;
  logic [hrms_pkg::SUM_W-1:0]    s1;
  logic [hrms_pkg::SQ_W-1:0]     s2;
  logic [hrms_pkg::ROW_W-1:0]    row;

  // shift-add multipliers
  logic [hrms_pkg::PROD_W-1:0]   ma;
  logic [hrms_pkg::CNT_W-1:0]    mbn;
  logic [hrms_pkg::PROD_W-1:0]   p1;
  logic [2*hrms_pkg::SUM_W-1:0]  mc;
  logic [hrms_pkg::SUM_W-1:0]    mb;
  logic [2*hrms_pkg::SUM_W-1:0]  p2;

  // restoring divider
  logic [hrms_pkg::DVS_W:0]      rem;
  logic [hrms_pkg::QUO_W-1:0]    q;
  logic [hrms_pkg::DVS_W-1:0]    dvs;
  logic [hrms_pkg::DVS_W+1:0]    div_t;
  logic                          div_ge;

  // digit-by-digit root
  logic [hrms_pkg::RAD_W-1:0]    rad;
  logic [hrms_pkg::SREM_W-1:0]   srem;
  logic [hrms_pkg::ROOT_W-1:0]   root;
  logic [hrms_pkg::SREM_W+1:0]   sq_t;
  logic [hrms_pkg::SREM_W-1:0]   trial;
  logic                          sq_ge;

  logic [hrms_pkg::MSC_W-1:0]    msc;
  logic [hrms_pkg::PROD_W-1:0]   var_num;
  logic [hrms_pkg::CNT_W-1:0]    row_inc;

  always_comb begin
    stat.n_zero    = (cnt == '0);
    stat.n_one     = (cnt == 11'd1);
    stat.slot_free = !out_valid || out_ready;

    div_t  = {rem, q[hrms_pkg::QUO_W-1]};
    div_ge = (div_t >= {2'b00, dvs});

    sq_t  = {srem, rad[hrms_pkg::RAD_W-1 -: 2]};
    trial = {root, 2'b01};
    sq_ge = (sq_t >= {2'b00, trial});

    // numerator stays nonnegative; clamp anyway
    var_num = (p1 >= {1'b0, p2}) ? (p1 - {1'b0, p2}) : '0;
    row_inc = {1'b0, row} + 11'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      cnt       <= '0;
      s1        <= '0;
      s2        <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      pend <= cmd.accept;
      if (pend && inc && cnt < hrms_pkg::MAX_BINS) begin
        cnt <= cnt + 11'd1;
        s1  <= s1 + {10'b0, bin_q};
        s2  <= s2 + {10'b0, sq_q};
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.op == hrms_pkg::OP_FINISH) begin
        out_valid <= 1'b1;
        cnt       <= '0;
        s1        <= '0;
        s2        <= '0;
        if (hist_q) row <= '0;
        else if (row_inc >= hrms_pkg::ROW_LIMIT) row <= '0;
        else row <= row_inc[hrms_pkg::ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bin_q <= bin_value;
      sq_q  <= bin_value * bin_value;
      inc   <= (bin_value != '0);
      if (row_end || histogram_end) hist_q <= histogram_end;
    end

    case (cmd.op)
      hrms_pkg::OP_DIVM_INIT: begin
        rem <= '0;
        dvs <= {9'b0, cnt};
        q   <= {s1, 67'b0};
      end
      hrms_pkg::OP_DIV_STEP: begin
        rem <= div_ge ? 21'(div_t - {2'b00, dvs}) : div_t[hrms_pkg::DVS_W:0];
        q   <= {q[hrms_pkg::QUO_W-2:0], div_ge};
      end
      hrms_pkg::OP_SAVE_MEAN: msc <= q[hrms_pkg::MSC_W-1:0];
      hrms_pkg::OP_MUL_INIT: begin
        ma  <= {11'b0, s2};
        mbn <= cnt;
        p1  <= '0;
        mc  <= {34'b0, s1};
        mb  <= s1;
        p2  <= '0;
      end
      hrms_pkg::OP_MUL_STEP: begin
        if (mbn[0]) p1 <= p1 + ma;
        ma  <= {ma[hrms_pkg::PROD_W-2:0], 1'b0};
        mbn <= {1'b0, mbn[hrms_pkg::CNT_W-1:1]};
        if (mb[0]) p2 <= p2 + mc;
        mc  <= {mc[2*hrms_pkg::SUM_W-2:0], 1'b0};
        mb  <= {1'b0, mb[hrms_pkg::SUM_W-1:1]};
      end
      hrms_pkg::OP_DIVV_INIT: begin
        rem <= '0;
        dvs <= 20'(cnt * (cnt - 11'd1));
        q   <= {var_num, 32'b0};
      end
      hrms_pkg::OP_SQRT_INIT: begin
        rad  <= {1'b0, q};
        srem <= '0;
        root <= '0;
      end
      hrms_pkg::OP_SQRT_STEP: begin
        rad  <= {rad[hrms_pkg::RAD_W-3:0], 2'b00};
        srem <= sq_ge ? 53'(sq_t - {2'b00, trial}) : sq_t[hrms_pkg::SREM_W-1:0];
        root <= {root[hrms_pkg::ROOT_W-2:0], sq_ge};
      end
      hrms_pkg::OP_FINISH: begin
        row_index     <= row;
        positive_bins <= cnt;
        last_row      <= hist_q;
        if (cnt == '0) begin
          status      <= hrms_pkg::ST_EMPTY;
          mean        <= '0;
          mean_fine   <= '0;
          std_dev     <= '0;
        end else if (cnt == 11'd1) begin
          status      <= hrms_pkg::ST_SINGLE;
          mean        <= msc[hrms_pkg::MSC_W-1:3];
          mean_fine   <= msc;
          std_dev     <= '0;
        end else begin
          status      <= hrms_pkg::ST_VALID;
          mean        <= msc[hrms_pkg::MSC_W-1:3];
          mean_fine   <= msc;
          std_dev     <= root[hrms_pkg::STD_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/histogram_row_mean_stddev.sv =====
// bins: one transfer per cycle while a row is open
// row close: for two or more positive bins the result comes from the bit-serial divider
//   (53 + 101 steps), the shift-add multipliers (34 steps) and the root unit (51 steps),
//   run one after another; one bin uses only the mean division, no bins use none of them
// input stalls while a closed row is computed; one finished result may wait in the output
// synchronous active-high reset clears accumulators, row counter and output valid
`default_nettype none
module histogram_row_mean_stddev (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [23:0]  s_tdata,   // bin_value
  input  wire          s_tlast,   // row_end
  input  wire          s_tuser,   // histogram_end
  output logic         m_tvalid,
  input  wire          m_tready,
  // row_index, positive_bins, mean, mean_fine, std_dev, status, zero pad
  output logic [151:0] m_tdata,
  output logic         m_tlast    // last_row
);

  hrms_pkg::cmd_t  cmd;
  hrms_pkg::stat_t stat;

  logic [hrms_pkg::ROW_W-1:0]    row_index;
  logic [hrms_pkg::CNT_W-1:0]    positive_bins;
  logic [hrms_pkg::MEAN_W-1:0]   mean;
  logic [hrms_pkg::MSC_W-1:0]    mean_fine;
  logic [hrms_pkg::STD_W-1:0]    std_dev;
  logic [hrms_pkg::STATUS_W-1:0] status;

  hrms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hrms_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .bin_value     (s_tdata),
    .row_end       (s_tlast),
    .histogram_end (s_tuser),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .row_index     (row_index),
    .positive_bins (positive_bins),
    .mean          (mean),
    .mean_fine     (mean_fine),
    .std_dev       (std_dev),
    .status        (status),
    .last_row      (m_tlast)
  );

  assign m_tdata = {6'b0, status, std_dev, mean_fine, mean, positive_bins, row_index};

endmodule
`default_nettype wire

// ===== src/hrms_checker.sv =====
`default_nettype none
module hrms_checker (
  input wire         clk,
  input wire         rst,
  input wire         m_tvalid,
  input wire         m_tready,
  input wire [151:0] m_tdata,
  input wire         m_tlast
);

  // a waiting result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[145:144] == hrms_pkg::ST_VALID
              || m_tdata[145:144] == hrms_pkg::ST_EMPTY
              || m_tdata[145:144] == hrms_pkg::ST_SINGLE)
    else $error("bad status code");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[145:144] == hrms_pkg::ST_EMPTY
      |-> m_tdata[20:10] == 11'd0 && m_tdata[143:21] == '0)
    else $error("empty row with nonzero fields");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[145:144] == hrms_pkg::ST_VALID |-> m_tdata[20:10] >= 11'd2)
    else $error("valid status with fewer than two bins");

  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

endmodule

bind histogram_row_mean_stddev hrms_checker u_hrms_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire
